@@ hdl/pdu_ack_timeout_tracker_assert.svh @@
// Assertion macros for the tracker checker.
`ifndef PDU_ACK_TIMEOUT_TRACKER_ASSERT_SVH
`define PDU_ACK_TIMEOUT_TRACKER_ASSERT_SVH

// same-cycle implication on clk, off while rst is high
`define PAT_COMB_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pat_chk: same-cycle check failed");

// next-cycle implication on clk, off while rst is high
`define PAT_NEXT_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pat_chk: next-cycle check failed");

`endif

@@ hdl/pat_pkg.sv @@
// Shared types and constants for the PDU ack timeout tracker.
`timescale 1ns / 1ps

package pat_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND,
    ST_UNTRK,
    ST_DRAIN
  } state_t;

  typedef enum logic {
    ALU_MATCH,
    ALU_AGE
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [15:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] cell_id;
    logic [2:0]  chan;
    logic [31:0] stamp;
  } entry_t;

  localparam logic [1:0] MODE_SEND  = 2'd0;
  localparam logic [1:0] MODE_ACK   = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [2:0] KIND_UNTRACKED = 3'd0;
  localparam logic [2:0] KIND_TRACKED   = 3'd1;
  localparam logic [2:0] KIND_DUP       = 3'd2;
  localparam logic [2:0] KIND_FULL      = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd4;

  localparam logic [15:0] TTL_RESET = 16'd3000;

  localparam int MAX_RESULTS = 32;
  localparam int RW          = $clog2(MAX_RESULTS + 1);

endpackage

@@ hdl/pat_mem.sv @@
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pat_mem #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  pat_pkg::entry_t            wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output pat_pkg::entry_t            rdata
);
  import pat_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pat_alu.sv @@
// Shared subtract-and-compare unit: id match or age-over-ttl test.
`timescale 1ns / 1ps

module pat_alu (
  input  pat_pkg::alu_req_t req,
  output logic              hit
);
  import pat_pkg::*;

  logic [31:0] diff;

  assign diff = req.lhs - req.rhs;

  always_comb begin
    case (req.op)
      ALU_MATCH: hit = (diff == 32'd0);
      ALU_AGE:   hit = (diff > {16'd0, req.limit});
      default:   hit = 1'b0;
    endcase
  end

endmodule

@@ hdl/pat_seq.sv @@
// Sequencer: entry scan, valid bits, entry count and output register.
`timescale 1ns / 1ps

module pat_seq #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [31:0]               pdu_id,
  input  logic [15:0]               cell_id,
  input  logic [2:0]                channel,
  input  logic [31:0]               now_ms,
  input  logic [15:0]               ttl,
  output logic                      mem_we,
  output logic [$clog2(DEPTH)-1:0]  mem_waddr,
  output pat_pkg::entry_t           mem_wdata,
  output logic                      mem_re,
  output logic [$clog2(DEPTH)-1:0]  mem_raddr,
  input  pat_pkg::entry_t           mem_rdata,
  output pat_pkg::alu_req_t         alu_req,
  input  logic                      alu_hit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                kind,
  output logic [31:0]               fail_pdu_id,
  output logic [15:0]               fail_cell,
  output logic [2:0]                fail_channel,
  output logic                      last
);
  import pat_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [1:0]  item_mode;
  logic [31:0] item_id;
  logic [15:0] item_cell;
  logic [2:0]  item_chan;
  logic [31:0] item_now;

  logic [IW-1:0]    idx, cmp_idx, free_idx;
  logic             idx_on, cmp_on, free_found, dup, ack_done;
  logic [DEPTH-1:0] vbit;
  logic [CW-1:0]    count;
  logic [RW-1:0]    n_cnt;
  entry_t           hold;
  logic             hold_v;

  logic        accept, out_free, scan_done, sweep_mode, full, hit, go, out_load;
  logic [2:0]  out_kind_next;
  entry_t      out_word_next;
  logic        out_last_next;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign scan_done  = !idx_on && !cmp_on;
  assign sweep_mode = (item_mode == MODE_SWEEP);
  assign full       = (count == CW'(DEPTH));

  assign alu_req.op    = sweep_mode ? ALU_AGE : ALU_MATCH;
  assign alu_req.lhs   = sweep_mode ? item_now : mem_rdata.id;
  assign alu_req.rhs   = sweep_mode ? mem_rdata.stamp : item_id;
  assign alu_req.limit = ttl;

  always_comb begin
    hit = cmp_on && vbit[cmp_idx] && alu_hit;
    if (sweep_mode) begin
      hit = hit && (n_cnt < RW'(MAX_RESULTS));
    end else if (item_mode == MODE_ACK) begin
      hit = hit && !ack_done;
    end
  end

  assign mem_raddr         = idx;
  assign mem_waddr         = free_idx;
  assign mem_wdata.id      = item_id;
  assign mem_wdata.cell_id = item_cell;
  assign mem_wdata.chan    = item_chan;
  assign mem_wdata.stamp   = item_now;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_SEND:  state_next = (pdu_id == 32'd0) ? ST_UNTRK : ST_SCAN;
            MODE_ACK:   state_next = (pdu_id == 32'd0) ? ST_IDLE : ST_SCAN;
            MODE_SWEEP: state_next = ST_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (item_mode)
            MODE_SEND:  state_next = ST_SEND;
            MODE_SWEEP: state_next = ST_DRAIN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEND:  if (out_free) state_next = ST_IDLE;
      ST_UNTRK: if (out_free) state_next = ST_IDLE;
      ST_DRAIN: if (!hold_v || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control and result select
  always_comb begin
    go            = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    out_kind_next = KIND_TIMEOUT;
    out_word_next = hold;
    out_last_next = 1'b0;
    case (state)
      ST_SCAN: begin
        go       = !(sweep_mode && hit && hold_v && !out_free);
        out_load = sweep_mode && hit && hold_v && out_free;
      end
      ST_SEND: begin
        out_load           = out_free;
        mem_we             = out_free && !dup && !full;
        out_word_next      = mem_wdata;
        out_last_next      = 1'b1;
        out_kind_next      = dup ? KIND_DUP : (full ? KIND_FULL : KIND_TRACKED);
      end
      ST_UNTRK: begin
        out_load      = out_free;
        out_word_next = mem_wdata;
        out_last_next = 1'b1;
        out_kind_next = KIND_UNTRACKED;
      end
      ST_DRAIN: begin
        out_load      = hold_v && out_free;
        out_last_next = 1'b1;
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  assign mem_re = go && idx_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx_on     <= 1'b0;
      cmp_on     <= 1'b0;
      free_found <= 1'b0;
      dup        <= 1'b0;
      ack_done   <= 1'b0;
      vbit       <= '0;
      count      <= '0;
      n_cnt      <= '0;
      hold_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx_on     <= 1'b1;
        cmp_on     <= 1'b0;
        free_found <= 1'b0;
        dup        <= 1'b0;
        ack_done   <= 1'b0;
        n_cnt      <= '0;
      end else if (go) begin
        cmp_on <= idx_on;
        if (idx_on && idx == IW'(DEPTH - 1)) begin
          idx_on <= 1'b0;
        end
        if (hit) begin
          case (item_mode)
            MODE_SWEEP: begin
              vbit[cmp_idx] <= 1'b0;
              count         <= count - 1'b1;
              n_cnt         <= n_cnt + 1'b1;
              hold_v        <= 1'b1;
            end
            MODE_ACK: begin
              vbit[cmp_idx] <= 1'b0;
              count         <= count - 1'b1;
              ack_done      <= 1'b1;
            end
            default: dup <= 1'b1;
          endcase
        end
        if (cmp_on && !vbit[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (state == ST_DRAIN && out_load) begin
        hold_v <= 1'b0;
      end
      if (state == ST_SEND && out_free) begin
        if (dup || full) begin
          vbit  <= '0;
          count <= '0;
        end else begin
          vbit[free_idx] <= 1'b1;
          count          <= count + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= mode;
      item_id   <= pdu_id;
      item_cell <= cell_id;
      item_chan <= channel;
      item_now  <= now_ms;
      idx       <= '0;
    end else if (go) begin
      cmp_idx <= idx;
      if (idx_on && idx != IW'(DEPTH - 1)) begin
        idx <= idx + 1'b1;
      end
      if (hit && sweep_mode) begin
        hold <= mem_rdata;
      end
      if (cmp_on && !vbit[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
    if (out_load) begin
      kind         <= out_kind_next;
      fail_pdu_id  <= out_word_next.id;
      fail_cell    <= out_word_next.cell_id;
      fail_channel <= out_word_next.chan;
      last         <= out_last_next;
    end
  end

endmodule

@@ hdl/pdu_ack_timeout_tracker.sv @@
// Usage:
//   Input channel (in_valid / in_stall) takes one word per item: mode, pdu_id,
//   cell_id, channel, now_ms. Mode 0 sends, 1 acks, 2 sweeps, 3 is ignored.
//   Output channel (out_valid / out_stall) gives kind, fail_pdu_id, fail_cell,
//   fail_channel and last; last marks the final word of an item. The user must write
//   ttl_ms via cfg_we / cfg_wdata only while idle; the block does not enforce this.
// Flow:
//   An untracked send (id zero) skips the scan and loads its word from the
//   ST_UNTRK state. A tracked send, an ack and a sweep each scan all DEPTH
//   entries through the single memory read port and the shared subtract/compare
//   unit, one entry per cycle unless a sweep pauses for a full output register.
//   A tracked send loads its word from ST_SEND once the scan ends; a sweep
//   ends in ST_DRAIN and an ack returns to idle. in_stall stays high until
//   the item is done. Mode 3 and an ack with id zero give no word.
// Stalls:
//   A sweep holds one expired entry back until the next one is found or the
//   scan ends (to set last). If out_stall keeps the output register full,
//   the scan pauses; nothing is dropped.
// Reset:
//   rst clears all valid bits, the entry count and out_valid; ttl_ms is 3000.
`timescale 1ns / 1ps

module pdu_ack_timeout_tracker #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] pdu_id,
  input  logic [15:0] cell_id,
  input  logic [2:0]  channel,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] fail_pdu_id,
  output logic [15:0] fail_cell,
  output logic [2:0]  fail_channel,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import pat_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [15:0] ttl;
  logic        mem_we, mem_re, alu_hit;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t      mem_wdata, mem_rdata;
  alu_req_t    alu_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (cfg_we) begin
      ttl <= cfg_wdata;
    end
  end

  pat_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pat_alu u_alu (
    .req (alu_req),
    .hit (alu_hit)
  );

  pat_seq #(.DEPTH(DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .pdu_id       (pdu_id),
    .cell_id      (cell_id),
    .channel      (channel),
    .now_ms       (now_ms),
    .ttl          (ttl),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .alu_req      (alu_req),
    .alu_hit      (alu_hit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .fail_pdu_id  (fail_pdu_id),
    .fail_cell    (fail_cell),
    .fail_channel (fail_channel),
    .last         (last)
  );

endmodule

@@ hdl/pat_chk.sv @@
// Port-level checker for the tracker, bound to the top level.
`timescale 1ns / 1ps
`include "pdu_ack_timeout_tracker_assert.svh"

module pat_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [31:0] fail_pdu_id,
  input logic [15:0] fail_cell,
  input logic [2:0]  fail_channel,
  input logic        last
);
  import pat_pkg::*;

  logic [54:0] out_word;

  assign out_word = {kind, fail_pdu_id, fail_cell, fail_channel, last};

  `PAT_NEXT_CHECK(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `PAT_COMB_CHECK(a_send_last, out_valid && kind != KIND_TIMEOUT, last)
  `PAT_COMB_CHECK(a_untracked_id, out_valid && kind == KIND_UNTRACKED, fail_pdu_id == 32'd0)
  `PAT_NEXT_CHECK(a_send_busy, in_valid && !in_stall && mode == MODE_SEND, in_stall)
  `PAT_NEXT_CHECK(a_rsvd_idle, in_valid && !in_stall && mode == MODE_RSVD, !in_stall)

endmodule

bind pdu_ack_timeout_tracker pat_chk u_pat_chk (.*);

@@ dv/pat_tb_pkg.sv @@
// Scoreboard for the PDU ack timeout tracker: shadow table, expected word queue and checks.
`timescale 1ns / 1ps

package pat_tb_pkg;
  import pat_pkg::*;

  localparam int TBL_DEPTH = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [15:0] cell_id;
    logic [2:0]  chan;
    logic        last;
  } pat_word_t;

  class pdu_tracker_shadow;
    bit          slot_used  [TBL_DEPTH];
    logic [31:0] slot_id    [TBL_DEPTH];
    logic [15:0] slot_cell  [TBL_DEPTH];
    logic [2:0]  slot_chan  [TBL_DEPTH];
    logic [31:0] slot_stamp [TBL_DEPTH];
    int          used_count;
    logic [15:0] ttl;
    pat_word_t   pending_words[$];
    int          mismatches;

    function new();
      ttl        = TTL_RESET;
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      used_count = 0;
    endfunction

    // random id currently held in the table, zero when empty
    function logic [31:0] live_id();
      int picks[$];
      foreach (slot_used[i]) if (slot_used[i]) picks.insert(picks.size(), i);
      if (picks.size() == 0) return 32'd0;
      return slot_id[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    function void take_item(logic [1:0] mode, logic [31:0] id, logic [15:0] cell_val,
                            logic [2:0] chan, logic [31:0] now);
      int          hit;
      int          n;
      logic [31:0] age;
      pat_word_t   w;
      hit = -1;
      case (mode)
        MODE_SEND: begin
          w = '{kind: KIND_TRACKED, id: id, cell_id: cell_val, chan: chan, last: 1'b1};
          if (id == 32'd0) begin
            w.kind = KIND_UNTRACKED;
          end else begin
            for (int i = 0; i < TBL_DEPTH; i++)
              if (hit < 0 && slot_used[i] && slot_id[i] == id) hit = i;
            if (hit >= 0) begin
              w.kind = KIND_DUP;
              wipe();
            end else if (used_count >= TBL_DEPTH) begin
              w.kind = KIND_FULL;
              wipe();
            end else begin
              for (int i = 0; i < TBL_DEPTH; i++)
                if (hit < 0 && !slot_used[i]) hit = i;
              slot_used[hit]  = 1'b1;
              slot_id[hit]    = id;
              slot_cell[hit]  = cell_val;
              slot_chan[hit]  = chan;
              slot_stamp[hit] = now;
              used_count++;
            end
          end
          pending_words.insert(pending_words.size(), w);
        end
        MODE_ACK: begin
          if (id != 32'd0) begin
            for (int i = 0; i < TBL_DEPTH; i++)
              if (hit < 0 && slot_used[i] && slot_id[i] == id) hit = i;
            if (hit >= 0) begin
              slot_used[hit] = 1'b0;
              used_count--;
            end
          end
        end
        MODE_SWEEP: begin
          n = 0;
          for (int i = 0; i < TBL_DEPTH && n < MAX_RESULTS; i++) begin
            if (slot_used[i]) begin
              age = now - slot_stamp[i];
              if (age > {16'd0, ttl}) begin
                w = '{kind: KIND_TIMEOUT, id: slot_id[i], cell_id: slot_cell[i],
                      chan: slot_chan[i], last: 1'b0};
                pending_words.insert(pending_words.size(), w);
                slot_used[i] = 1'b0;
                used_count--;
                n++;
              end
            end
          end
          if (n > 0) begin
            pending_words[pending_words.size() - 1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void field_check(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        mismatches++;
      end
    endfunction

    function void compare_word(pat_word_t got);
      pat_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d id %0h",
                 $time, got.kind, got.id);
        $display("  cell %0h chan %0d last %0b", got.cell_id, got.chan, got.last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      field_check("kind", 32'(want.kind), 32'(got.kind));
      field_check("fail_pdu_id", want.id, got.id);
      field_check("fail_cell", 32'(want.cell_id), 32'(got.cell_id));
      field_check("fail_channel", 32'(want.chan), 32'(got.chan));
      field_check("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Testbench top for the PDU ack timeout tracker: directed and random traffic with random stalls.
`timescale 1ns / 1ps

module tb_top;
  import pat_pkg::*;
  import pat_tb_pkg::*;

  localparam int DEPTH         = 32;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 410;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [31:0] pdu_id;
  logic [15:0] cell_id;
  logic [2:0]  channel;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind;
  logic [31:0] fail_pdu_id;
  logic [15:0] fail_cell;
  logic [2:0]  fail_channel;
  logic        last;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  pdu_tracker_shadow shadow;
  pat_word_t         seen_word;
  int                cycles;
  int                out_hold;
  int                hold_draw;
  bit                calm;
  int                issued;
  logic [31:0]       clock_ms;
  logic [31:0]       serial_id;
  logic [15:0]       cur_ttl;

  pdu_ack_timeout_tracker #(.DEPTH(DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .pdu_id       (pdu_id),
    .cell_id      (cell_id),
    .channel      (channel),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .fail_pdu_id  (fail_pdu_id),
    .fail_cell    (fail_cell),
    .fail_channel (fail_channel),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output side: each word waits a drawn number of stalled cycles once it shows
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word = '{kind: kind, id: fail_pdu_id, cell_id: fail_cell, chan: fail_channel,
                    last: last};
      shadow.compare_word(seen_word);
    end
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      hold_draw = calm ? 0 : $urandom_range(0, 9);
      out_hold  <= hold_draw;
      out_stall <= (hold_draw != 0);
    end else if (out_valid && out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] m, input logic [31:0] id,
                           input logic [15:0] cell_val, input logic [2:0] chan,
                           input logic [31:0] now);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    pdu_id   <= id;
    cell_id  <= cell_val;
    channel  <= chan;
    now_ms   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_item(m, id, cell_val, chan, now);
    if (m != MODE_RSVD) issued++;
  endtask

  // all words out, then room for an ack scan that gives none
  task automatic drain_and_wait();
    in_valid <= 1'b0;
    while (shadow.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          r;
    int          k;
    logic [31:0] id;
    shadow    = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_SEND;
    pdu_id    = 32'd0;
    cell_id   = 16'd0;
    channel   = 3'd0;
    now_ms    = 32'd0;
    cfg_we    = 1'b0;
    cfg_wdata = 16'd0;
    calm      = 1'b0;
    issued    = 0;
    clock_ms  = 32'd0;
    serial_id = 32'h100;
    cur_ttl   = TTL_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, ttl at reset value
    push_item(MODE_SEND, 32'd0, 16'hFFFF, 3'd7, 32'd0);
    push_item(MODE_SEND, 32'hFFFF_FFFF, 16'd0, 3'd0, 32'd1000);
    push_item(MODE_SEND, 32'd1, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    push_item(MODE_SEND, 32'd2, 16'h1234, 3'd3, 32'd1000);
    push_item(MODE_SEND, 32'd2, 16'h4321, 3'd4, 32'd1001);
    push_item(MODE_ACK, 32'd2, 16'd0, 3'd0, 32'd1001);
    push_item(MODE_SEND, 32'd10, 16'd10, 3'd1, 32'd5000);
    push_item(MODE_SEND, 32'd11, 16'd11, 3'd2, 32'd5000);
    push_item(MODE_SEND, 32'd12, 16'd12, 3'd5, 32'd5000);
    push_item(MODE_ACK, 32'd11, 16'd0, 3'd0, 32'd5000);
    push_item(MODE_ACK, 32'd0, 16'd0, 3'd0, 32'd5000);
    push_item(MODE_RSVD, $urandom(), 16'($urandom()), 3'($urandom()), $urandom());
    push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, 32'd8000);
    push_item(MODE_SEND, 32'd13, 16'd13, 3'd6, 32'd6000);
    push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, 32'd8001);
    push_item(MODE_SEND, 32'd14, 16'd14, 3'd7, 32'hFFFF_FF00);
    push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, 32'h0000_0100);
    push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, 32'h0000_0AB9);
    push_item(MODE_ACK, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'h0000_0AB9);
    push_item(MODE_SEND, 32'd0, 16'd0, 3'd0, 32'hFFFF_FFFF);
    push_item(MODE_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'd0);

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      drain_and_wait();
      case (phase % 5)
        0:       cur_ttl = 16'd0;
        1:       cur_ttl = 16'hFFFF;
        2:       cur_ttl = 16'($urandom());
        3:       cur_ttl = TTL_RESET;
        default: cur_ttl = 16'($urandom_range(1, 200));
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= cur_ttl;
      @(posedge clk);
      cfg_we    <= 1'b0;
      shadow.ttl = cur_ttl;
      calm     = (phase % 4 == 3);
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom();

      for (int blk = 0; blk < 5 && issued < RANDOM_ITEMS; blk++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // mixed traffic over a small id pool
            repeat (12) begin
              r = $urandom_range(0, 9);
              clock_ms = clock_ms + $urandom_range(0, cur_ttl / 8 + 4);
              if (r < 5)
                push_item(MODE_SEND, $urandom_range(1, 48), 16'($urandom()), 3'($urandom()),
                          clock_ms);
              else if (r == 5)
                push_item(MODE_SEND, 32'd0, 16'($urandom()), 3'($urandom()), clock_ms);
              else if (r < 8)
                push_item(MODE_ACK, shadow.live_id(), 16'($urandom()), 3'($urandom()),
                          clock_ms);
              else begin
                if (r == 9) clock_ms = clock_ms + cur_ttl;
                push_item(MODE_SWEEP, $urandom(), 16'($urandom()), 3'($urandom()), clock_ms);
              end
            end
          end
          4, 5: begin
            // fill, overflow, refill, then sweep far ahead
            while (shadow.used_count < DEPTH) begin
              serial_id = serial_id + $urandom_range(1, 3);
              clock_ms  = clock_ms + $urandom_range(0, 3);
              push_item(MODE_SEND, serial_id, 16'($urandom()), 3'($urandom()), clock_ms);
            end
            serial_id = serial_id + 1;
            push_item(MODE_SEND, serial_id, 16'($urandom()), 3'($urandom()), clock_ms);
            while (shadow.used_count < DEPTH) begin
              serial_id = serial_id + $urandom_range(1, 3);
              clock_ms  = clock_ms + $urandom_range(0, 3);
              push_item(MODE_SEND, serial_id, 16'($urandom()), 3'($urandom()), clock_ms);
            end
            clock_ms = clock_ms + cur_ttl + $urandom_range(0, 200);
            push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, clock_ms);
          end
          6, 7: begin
            // staggered sends, sweeps around the ttl edge
            k = $urandom_range(1, 12);
            repeat (k) begin
              serial_id = serial_id + $urandom_range(1, 3);
              clock_ms  = clock_ms + $urandom_range(0, cur_ttl / 4 + 2);
              push_item(MODE_SEND, serial_id, 16'($urandom()), 3'($urandom()), clock_ms);
            end
            repeat (3) begin
              clock_ms = clock_ms + $urandom_range(0, cur_ttl / 2 + 2);
              push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, clock_ms);
            end
          end
          8: begin
            repeat (8)
              push_item(2'($urandom()), ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom(),
                        16'($urandom()), 3'($urandom()), $urandom());
          end
          default: begin
            push_item(MODE_ACK, 32'd0, 16'($urandom()), 3'($urandom()), clock_ms);
            push_item(MODE_ACK, $urandom(), 16'($urandom()), 3'($urandom()), clock_ms);
            id = shadow.live_id();
            push_item(MODE_SEND, (id == 32'd0) ? 32'd7 : id, 16'($urandom()), 3'($urandom()),
                      clock_ms);
            push_item(MODE_RSVD, $urandom(), 16'($urandom()), 3'($urandom()), $urandom());
            // time behind the newest stamps
            push_item(MODE_SWEEP, 32'd0, 16'd0, 3'd0, clock_ms - 1);
          end
        endcase
      end
      phase++;
    end

    drain_and_wait();
    if (shadow.mismatches == 0 && shadow.pending_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
